@@ src/windowed_latency_stats_core_macros.svh @@
// Assertion helpers shared by the checker files.
// Both macros clock on i_clk and stay quiet while i_rst_n is low.
`ifndef WINDOWED_LATENCY_STATS_CORE_MACROS_SVH
`define WINDOWED_LATENCY_STATS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/wls_pkg.sv @@
package wls_pkg;

    // Default ring size.
    localparam int RING_DEPTH_DEF = 64;

    // Field widths.
    localparam int IN_TIME_W   = 16;
    localparam int TIME_W      = 12;
    localparam int CFG_W       = 7;
    localparam int PCT_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int OUT_PAD_W   = 7;
    localparam int OUT_DATA_W  = 88;

    // Stored sample codes.
    localparam logic [TIME_W-1:0] TIME_CAP  = 12'hFFE;
    localparam logic [TIME_W-1:0] LOST_MARK = 12'hFFF;

    // Loss reported when the window holds no reply, and the percentage scale.
    localparam logic [PCT_W-1:0] LOSS_ALL   = 7'd100;
    localparam int               LOSS_SCALE = 100;

    // Which quotient the shared divider is working on.
    localparam logic [1:0] DIV_AVG  = 2'd0;
    localparam logic [1:0] DIV_LOSS = 2'd1;
    localparam logic [1:0] DIV_JIT  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       ring_wr;
        logic       walk_clr;
        logic       walk_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

@@ src/windowed_latency_stats_core.sv @@
// Sliding-window ping statistics.
// Input stream: one word per ping, s_axis_tdata holds the round trip time in ms
// and s_axis_tuser flags a timeout. Each word goes into a ring of window-length
// entries (times saturate at 4094, a timeout is kept as a lost mark), after
// which the window is walked in index order and one result word is produced:
// last reply, minimum, maximum, average, loss percentage, jitter and counts.
// The window length is written through i_cfg_we / i_cfg_wdata; the user must
// do so only while the block is idle, which the block itself does not enforce;
// a write empties the window and restarts at entry zero. The ring is walked
// through the single read port over the filled entries (up to the window
// length), and the three quotients are worked out in turn on the shared
// bit-serial divider, which is W = 12 + clog2(RING_DEPTH + 1) bits wide.
// One word is processed at a time; s_axis_tready returns once the result is in
// the output register, so the next word is taken while the result waits.
// A stalled receiver holds the result in place and the block stops before its
// next hand-over. Reset empties the window, sets the length to RING_DEPTH and
// clears the last reply; no clearing pass is needed.
module windowed_latency_stats_core
    import wls_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,    // window_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TIME_W-1:0]  s_axis_tdata,   // response_time
    input  logic                  s_axis_tuser,   // timed_out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // last_time, min_time, max_time, avg_time, loss_percent, jitter,
    // sample_total, reply_total, then zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    wls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wls_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_time   (s_axis_tdata),
        .i_in_lost   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

@@ src/wls_div.sv @@
module wls_div
    import wls_pkg::*;
#(
    parameter int DVD_W = 19,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    // Step counter, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    // Quotient shifts in from the bottom as the dividend shifts out of the top.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ src/wls_dp.sv @@
module wls_dp
    import wls_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [IN_TIME_W-1:0]  i_in_time,
    input  logic                  i_in_lost,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = TIME_W + CNT_W;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Window geometry and write side.
    logic [CNT_W-1:0]  r_win;
    logic [AW-1:0]     r_pos;
    logic [CNT_W-1:0]  r_fill;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_in_val;

    // Ring store.
    logic [TIME_W-1:0] r_mem [RING_DEPTH];

    // Walk side.
    logic [AW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [TIME_W-1:0] r_rd_data;
    logic [CNT_W-1:0]  r_replies;
    logic [SUM_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_jsum;
    logic [TIME_W-1:0] r_lo;
    logic [TIME_W-1:0] r_hi;
    logic [TIME_W-1:0] r_prev;

    // Quotients and output word.
    logic [TIME_W-1:0]     r_q_avg;
    logic [PCT_W-1:0]      r_q_loss;
    logic [TIME_W-1:0]     r_q_jit;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CMP_W-1:0]  cfg_wide;
    logic [CMP_W-1:0]  cfg_win;
    logic [TIME_W-1:0] in_sat;
    logic [AW-1:0]     pos_eff;
    logic [CNT_W-1:0]  pos_inc;
    logic [AW-1:0]     n_pos;
    logic              rd_reply;
    logic [TIME_W-1:0] absdiff;
    logic [CNT_W-1:0]  lost_cnt;
    logic [SUM_W-1:0]  div_dvd;
    logic [CNT_W-1:0]  div_dvs;
    logic [SUM_W-1:0]  div_quo;
    logic              div_done;
    logic              has_reply;
    logic              multi_reply;
    logic [TIME_W-1:0] f_avg;
    logic [PCT_W-1:0]  f_loss;
    logic [TIME_W-1:0] f_jit;

    // Window length written through the register port, held within 1..RING_DEPTH.
    always_comb begin
        cfg_wide = CMP_W'(i_cfg_wdata);
        if (cfg_wide == '0) begin
            cfg_win = CMP_W'(1);
        end else if (cfg_wide > CMP_W'(RING_DEPTH)) begin
            cfg_win = CMP_W'(RING_DEPTH);
        end else begin
            cfg_win = cfg_wide;
        end
    end

    // Incoming time saturates just below the lost mark.
    assign in_sat = (i_in_time > IN_TIME_W'(TIME_CAP)) ? TIME_CAP : i_in_time[TIME_W-1:0];

    // Write position and its successor, wrapping at the window length.
    always_comb begin
        pos_eff = (CNT_W'(r_pos) >= r_win) ? '0 : r_pos;
        pos_inc = CNT_W'(pos_eff) + CNT_W'(1);
        n_pos   = (pos_inc >= r_win) ? '0 : AW'(pos_inc);
    end

    // Window, position, fill count and last reply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= CNT_W'(RING_DEPTH);
            r_pos  <= '0;
            r_fill <= '0;
            r_last <= '0;
        end else begin
            if (i_cfg_we) begin
                r_win  <= CNT_W'(cfg_win);
                r_pos  <= '0;
                r_fill <= '0;
            end else if (i_cmd.ring_wr) begin
                r_pos <= n_pos;
                if (r_fill != r_win) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.capture && !i_in_lost) begin
                r_last <= in_sat;
            end
        end
    end

    // Captured word as it will be stored.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_val <= i_in_lost ? LOST_MARK : in_sat;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_wr) begin
            r_mem[pos_eff] <= r_in_val;
        end
        if (i_cmd.walk_step) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Walk address and read-data valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.walk_step;
            if (i_cmd.walk_clr) begin
                r_addr <= '0;
            end else if (i_cmd.walk_step) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // Entries below the fill count are exactly the occupied ones.
    assign o_sts.walk_last = (CNT_W'(r_addr) == (r_fill - CNT_W'(1)));

    // Running statistics over the replies met in index order.
    always_comb begin
        rd_reply = (r_rd_data != LOST_MARK);
        absdiff  = (r_rd_data > r_prev) ? (r_rd_data - r_prev) : (r_prev - r_rd_data);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_clr) begin
            r_replies <= '0;
            r_total   <= '0;
            r_jsum    <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
        end else if (r_rd_vld && rd_reply) begin
            r_replies <= r_replies + CNT_W'(1);
            r_total   <= r_total + SUM_W'(r_rd_data);
            r_prev    <= r_rd_data;
            if (r_replies == '0) begin
                r_lo <= r_rd_data;
                r_hi <= r_rd_data;
            end else begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
                r_jsum <= r_jsum + SUM_W'(absdiff);
            end
        end
    end

    // Operands for the shared divider.
    assign lost_cnt = r_fill - r_replies;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_AVG: begin
                div_dvd = r_total;
                div_dvs = r_replies;
            end
            DIV_LOSS: begin
                div_dvd = SUM_W'(lost_cnt) * SUM_W'(LOSS_SCALE);
                div_dvs = r_fill;
            end
            DIV_JIT: begin
                div_dvd = r_jsum;
                div_dvs = r_replies - CNT_W'(1);
            end
            default: begin
                div_dvd = '0;
                div_dvs = CNT_W'(1);
            end
        endcase
    end

    wls_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    assign o_sts.div_done = div_done;

    // Keep each quotient as it completes.
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.div_sel)
                DIV_AVG:  r_q_avg  <= TIME_W'(div_quo);
                DIV_LOSS: r_q_loss <= PCT_W'(div_quo);
                DIV_JIT:  r_q_jit  <= TIME_W'(div_quo);
                default:  r_q_avg  <= r_q_avg;
            endcase
        end
    end

    // Windows with no reply report fixed average, loss and jitter; with only one, the jitter is zero.
    always_comb begin
        has_reply   = (r_replies != '0);
        multi_reply = (r_replies > CNT_W'(1));
        f_avg       = has_reply ? r_q_avg : '0;
        f_loss      = has_reply ? r_q_loss : LOSS_ALL;
        f_jit       = multi_reply ? r_q_jit : '0;
    end

    // Output register: holds the word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, CNT_OUT_W'(r_replies), CNT_OUT_W'(r_fill),
                           f_jit, f_loss, f_avg, r_hi, r_lo, r_last};
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

@@ src/wls_ctrl.sv @@
module wls_ctrl
    import wls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_WRITE    = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_DRAIN    = 3'd3;
    localparam logic [2:0] S_DIV_GO   = 3'd4;
    localparam logic [2:0] S_DIV_WAIT = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_sel;
    logic [1:0] n_sel;

    // Sequencing: store, walk the window, three divisions, hand over the word.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.ring_wr  = 1'b1;
                o_cmd.walk_clr = 1'b1;
                n_state        = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_sel   = DIV_AVG;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (r_sel == DIV_JIT) begin
                        n_state = S_DONE;
                    end else begin
                        n_sel   = (r_sel == DIV_AVG) ? DIV_LOSS : DIV_JIT;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= DIV_AVG;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/wls_checker.sv @@
`include "windowed_latency_stats_core_macros.svh"

module wls_checker
    import wls_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A result waiting on the receiver stays offered and unchanged.
    `WLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `WLS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // One word at a time: the input closes right after a word is taken.
    `WLS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open after accept")

    // Loss never exceeds the whole window.
    `WLS_ASSERT_SAME(a_loss_range, m_axis_tvalid, m_axis_tdata[54:48] <= LOSS_ALL, "loss above 100")

    // Replies are a subset of samples and the extremes are ordered.
    `WLS_ASSERT_SAME(a_counts_order, m_axis_tvalid, (m_axis_tdata[80:74] <= m_axis_tdata[73:67]) && (m_axis_tdata[23:12] <= m_axis_tdata[35:24]), "counts or extremes out of order")

endmodule

bind windowed_latency_stats_core wls_checker u_wls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/windowed_latency_stats_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both streams of the latency statistics
// core, predicts the statistics word for every accepted ping and compares
// each delivered word with the oldest prediction.
module windowed_latency_stats_checker
    import wls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_TIME_W-1:0]  i_in_time,
    input  logic                  i_in_timeout,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    // One statistics word, last_time in the lowest bits.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [CNT_OUT_W-1:0] reply_total;
        logic [CNT_OUT_W-1:0] sample_total;
        logic [TIME_W-1:0]    jitter;
        logic [PCT_W-1:0]     loss_percent;
        logic [TIME_W-1:0]    avg_time;
        logic [TIME_W-1:0]    max_time;
        logic [TIME_W-1:0]    min_time;
        logic [TIME_W-1:0]    last_time;
    } t_stats;

    // Shadow copy of the window: bit TIME_W marks an occupied entry.
    logic [TIME_W:0]  ring_shadow [RING_DEPTH_DEF];
    int               next_slot;
    int               window_len;
    logic [TIME_W-1:0] held_reply;

    t_stats expected_stats_q [$];

    // Empties the shadow window and restarts at entry zero.
    function automatic void clear_window();
        for (int k = 0; k < RING_DEPTH_DEF; k++) begin
            ring_shadow[k] = '0;
        end
        next_slot = 0;
    endfunction

    // Stores one ping in the shadow window and works out the statistics word.
    function automatic t_stats absorb_ping(logic [IN_TIME_W-1:0] rt, logic lost);
        t_stats s;
        int     pos;
        int     samples;
        int     replies;
        int     lo;
        int     hi;
        int     prev;
        int     total;
        int     jsum;
        int     v;
        s       = '0;
        samples = 0;
        replies = 0;
        lo      = 0;
        hi      = 0;
        prev    = 0;
        total   = 0;
        jsum    = 0;
        pos = (next_slot >= window_len) ? 0 : next_slot;
        if (lost) begin
            ring_shadow[pos] = {1'b1, LOST_MARK};
        end else begin
            held_reply = (rt > IN_TIME_W'(TIME_CAP)) ? TIME_CAP : rt[TIME_W-1:0];
            ring_shadow[pos] = {1'b1, held_reply};
        end
        next_slot = (pos + 1 >= window_len) ? 0 : pos + 1;

        // Walk the window in index order, skipping empty entries.
        for (int k = 0; k < window_len; k++) begin
            if (!ring_shadow[k][TIME_W]) continue;
            samples++;
            if (ring_shadow[k][TIME_W-1:0] == LOST_MARK) continue;
            v = int'(ring_shadow[k][TIME_W-1:0]);
            replies++;
            total += v;
            if (replies == 1) begin
                lo = v;
                hi = v;
            end else begin
                if (v < lo) lo = v;
                if (v > hi) hi = v;
                jsum += (v > prev) ? (v - prev) : (prev - v);
            end
            prev = v;
        end

        s.last_time    = held_reply;
        s.sample_total = CNT_OUT_W'(samples);
        s.reply_total  = CNT_OUT_W'(replies);
        if (replies > 0) begin
            s.min_time     = TIME_W'(lo);
            s.max_time     = TIME_W'(hi);
            s.avg_time     = TIME_W'(total / replies);
            s.loss_percent = PCT_W'(((samples - replies) * LOSS_SCALE) / samples);
            s.jitter       = (replies > 1) ? TIME_W'(jsum / (replies - 1)) : '0;
        end else begin
            s.loss_percent = LOSS_ALL;
        end
        return s;
    endfunction

    function automatic void check_field(string fname, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            o_mismatches++;
        end
    endfunction

    // Delivered words are checked before new pings are absorbed.
    always @(posedge i_clk) begin
        t_stats want;
        t_stats got;
        if (!i_rst_n) begin
            clear_window();
            held_reply = '0;
            window_len = RING_DEPTH_DEF;
            expected_stats_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_stats'(i_out_data);
                if (expected_stats_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_out_data);
                    o_mismatches++;
                end else begin
                    want = expected_stats_q.pop_front();
                    check_field("last_time", int'(want.last_time), int'(got.last_time));
                    check_field("min_time", int'(want.min_time), int'(got.min_time));
                    check_field("max_time", int'(want.max_time), int'(got.max_time));
                    check_field("avg_time", int'(want.avg_time), int'(got.avg_time));
                    check_field("loss_percent", int'(want.loss_percent),
                                int'(got.loss_percent));
                    check_field("jitter", int'(want.jitter), int'(got.jitter));
                    check_field("sample_total", int'(want.sample_total),
                                int'(got.sample_total));
                    check_field("reply_total", int'(want.reply_total),
                                int'(got.reply_total));
                    o_checked++;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) begin
                    window_len = 1;
                end else if (int'(i_cfg_wdata) > RING_DEPTH_DEF) begin
                    window_len = RING_DEPTH_DEF;
                end else begin
                    window_len = int'(i_cfg_wdata);
                end
                clear_window();
            end
            if (i_in_valid && i_in_ready) begin
                expected_stats_q.push_back(absorb_ping(i_in_time, i_in_timeout));
            end
        end
        o_pending = expected_stats_q.size();
    end

endmodule

@@ dv/tb_windowed_latency_stats_core.sv @@
`timescale 1ns / 100ps

// Drives pings and window settings into the latency statistics core and
// gives the verdict from the checker's mismatch count.
module tb_windowed_latency_stats_core;
    import wls_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 140;
    localparam int CFG_SETTLE   = 4;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata    = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TIME_W-1:0]  s_axis_tdata   = '0;
    logic                  s_axis_tuser   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int cycle_count   = 0;
    int pings_sent    = 0;
    int window_writes = 0;

    // Idling controls for the sender and the receiver.
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;
    int hold_asks = 0;

    windowed_latency_stats_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    windowed_latency_stats_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_time    (s_axis_tdata),
        .i_in_timeout (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Run stopped after %0d cycles without finishing.", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while calm.
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Receiver: random stalls, and one long hold when asked for.
    initial begin : receiver
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_asks != holds_done) begin
                holds_done = hold_asks;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(rx_calm);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Offers one ping word and returns at the edge that accepts it.
    task automatic send_ping(input logic [IN_TIME_W-1:0] rt, input logic lost);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TIME_W'($urandom);
            s_axis_tuser  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rt;
        s_axis_tuser  <= lost;
        do @(posedge i_clk); while (!s_axis_tready);
        pings_sent++;
    endtask

    // Window writes happen only once every result has been delivered.
    task automatic set_window(input logic [CFG_W-1:0] len);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_writes++;
    endtask

    // Random pings: spread 0 keeps times small, otherwise a mix that
    // includes saturating and full-range values.
    task automatic run_random_pings(input int count, input int lost_pct,
                                    input int spread, input int hold_at);
        logic [IN_TIME_W-1:0] rt;
        int                   sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 9);
            if (spread == 0 || sel < 4) begin
                rt = IN_TIME_W'($urandom_range(0, 300));
            end else if (sel < 6) begin
                rt = IN_TIME_W'($urandom_range(4080, 4110));
            end else if (sel < 8) begin
                rt = IN_TIME_W'($urandom);
            end else begin
                rt = IN_TIME_W'($urandom_range(0, 4094));
            end
            if (k == hold_at) hold_asks++;
            send_ping(rt, $urandom_range(0, 99) < lost_pct);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default window: empty start, extremes and saturation.
        send_ping(16'd0, 1'b1);
        send_ping(16'd0, 1'b0);
        send_ping(16'hFFFF, 1'b0);
        send_ping(16'd4094, 1'b0);
        send_ping(16'd4095, 1'b0);
        send_ping(16'd4093, 1'b0);
        send_ping(16'hFFFF, 1'b1);
        send_ping(16'hAAAA, 1'b0);
        send_ping(16'h5555, 1'b0);
        send_ping(16'd1, 1'b0);
        send_ping(16'd2048, 1'b0);
        send_ping(16'h1000, 1'b0);

        // Single-entry window, including a window that holds only a loss.
        set_window(CFG_W'(1));
        send_ping(16'd100, 1'b0);
        send_ping(16'd0, 1'b1);
        send_ping(16'd200, 1'b0);

        // A length of zero acts as one, an oversize length as the full ring.
        set_window(CFG_W'(0));
        send_ping(16'd7, 1'b0);
        send_ping(16'hFFFF, 1'b1);
        send_ping(16'd9, 1'b0);
        set_window(CFG_W'(127));
        send_ping(16'd3000, 1'b0);
        send_ping(16'd5, 1'b0);
        send_ping(16'd0, 1'b1);
        set_window(CFG_W'(2));
        send_ping(16'd10, 1'b0);
        send_ping(16'd50, 1'b0);
        send_ping(16'd0, 1'b1);
        send_ping(16'd30, 1'b0);

        // Random phases over several window lengths and loss rates.
        set_window(CFG_W'(8));
        run_random_pings(200, 20, 1, 40);
        set_window(CFG_W'(1));
        run_random_pings(60, 30, 1, -1);
        set_window(CFG_W'(64));
        run_random_pings(300, 10, 1, -1);
        set_window(CFG_W'(3));
        run_random_pings(150, 50, 1, -1);
        set_window(CFG_W'($urandom_range(2, 63)));
        run_random_pings(200, 5, 0, -1);
        set_window(CFG_W'(64));
        run_random_pings(200, 95, 1, -1);

        // A stretch with no idling on either side.
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        set_window(CFG_W'($urandom_range(1, 64)));
        run_random_pings(200, 25, 1, -1);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        set_window(CFG_W'(64));
        run_random_pings(150, 0, 1, -1);

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pings across %0d window writes; %0d statistics words checked.",
                 pings_sent, window_writes, checked_count);
        $display("Covered saturation, all-lost windows, odd lengths and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
